/* rtl/pse_pkg.sv */
// Shared constants, codes and types of the postfix stack evaluator.
`default_nettype none

package pse_pkg;

    localparam int DATA_W          = 64;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int STEP_W          = $clog2(DATA_W);

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_OPER = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;
    localparam logic [2:0] OP_POW = 3'd5;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd1;
    localparam logic [2:0] STAT_DIVZERO   = 3'd2;
    localparam logic [2:0] STAT_MODZERO   = 3'd3;
    localparam logic [2:0] STAT_NEGEXP    = 3'd4;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd5;
    localparam logic [2:0] STAT_EMPTY     = 3'd6;
    localparam logic [2:0] STAT_EXTRA     = 3'd7;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } alu_cmd_t;

endpackage

`default_nettype wire

/* rtl/pse_alu.sv */
// Iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide, power.
`default_nettype none

module pse_alu
    import pse_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire alu_cmd_t          cmd,
    input  wire logic [DATA_W-1:0] opnd_a,
    input  wire logic [DATA_W-1:0] opnd_b,
    output logic                   done,
    output logic [DATA_W-1:0]      result
);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_DIV  = 3'd2;
    localparam logic [2:0] A_DFIN = 3'd3;
    localparam logic [2:0] A_POW  = 3'd4;
    localparam logic [2:0] A_DONE = 3'd5;

    localparam logic [1:0] RET_OUT  = 2'd0;
    localparam logic [1:0] RET_ACC  = 2'd1;
    localparam logic [1:0] RET_BASE = 2'd2;

    logic [2:0]        st_reg, st_next;
    logic [1:0]        ret_reg, ret_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] y_reg, y_next;
    logic [DATA_W-1:0] z_reg, z_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] base_reg, base_next;
    logic [DATA_W-1:0] exp_reg, exp_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              negq_reg, negq_next;
    logic              negr_reg, negr_next;
    logic              mod_reg, mod_next;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W+1:0] rem_diff;

    assign done   = (st_reg == A_DONE);
    assign result = res_reg;

    always_comb begin
        st_next   = st_reg;
        ret_next  = ret_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        acc_next  = acc_reg;
        base_next = base_reg;
        exp_next  = exp_reg;
        res_next  = res_reg;
        step_next = step_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        mod_next  = mod_reg;
        // One restoring-division step: shift in the next dividend bit, try the subtract.
        rem_shift = {z_reg, y_reg[DATA_W-1]};
        rem_diff  = {1'b0, rem_shift} - {2'b00, x_reg};

        unique case (st_reg)
            A_IDLE: begin
                if (cmd.start) begin
                    case (cmd.op) inside
                        OP_ADD: begin
                            res_next = opnd_b + opnd_a;
                            st_next  = A_DONE;
                        end
                        OP_SUB: begin
                            res_next = opnd_b - opnd_a;
                            st_next  = A_DONE;
                        end
                        OP_MUL: begin
                            x_next   = opnd_b;
                            y_next   = opnd_a;
                            z_next   = '0;
                            ret_next = RET_OUT;
                            st_next  = A_MUL;
                        end
                        OP_DIV, OP_MOD: begin
                            x_next    = opnd_a[DATA_W-1] ? (DATA_W'(0) - opnd_a) : opnd_a;
                            y_next    = opnd_b[DATA_W-1] ? (DATA_W'(0) - opnd_b) : opnd_b;
                            z_next    = '0;
                            step_next = '0;
                            negq_next = opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1];
                            negr_next = opnd_b[DATA_W-1];
                            mod_next  = (cmd.op == OP_MOD);
                            st_next   = A_DIV;
                        end
                        OP_POW: begin
                            acc_next  = DATA_W'(1);
                            base_next = opnd_b;
                            exp_next  = opnd_a;
                            st_next   = A_POW;
                        end
                        default: begin
                            st_next = A_IDLE;
                        end
                    endcase
                end
            end
            A_MUL: begin
                if (y_reg == '0) begin
                    case (ret_reg)
                        RET_ACC: begin
                            acc_next = z_reg;
                            exp_next = {exp_reg[DATA_W-1:1], 1'b0};
                            st_next  = A_POW;
                        end
                        RET_BASE: begin
                            base_next = z_reg;
                            exp_next  = exp_reg >> 1;
                            st_next   = A_POW;
                        end
                        default: begin
                            res_next = z_reg;
                            st_next  = A_DONE;
                        end
                    endcase
                end else begin
                    z_next = y_reg[0] ? (z_reg + x_reg) : z_reg;
                    x_next = x_reg << 1;
                    y_next = y_reg >> 1;
                end
            end
            A_DIV: begin
                if (!rem_diff[DATA_W+1]) begin
                    z_next = rem_diff[DATA_W-1:0];
                end else begin
                    z_next = rem_shift[DATA_W-1:0];
                end
                y_next    = {y_reg[DATA_W-2:0], ~rem_diff[DATA_W+1]};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DATA_W - 1)) begin
                    st_next = A_DFIN;
                end
            end
            A_DFIN: begin
                if (mod_reg) begin
                    res_next = negr_reg ? (DATA_W'(0) - z_reg) : z_reg;
                end else begin
                    res_next = negq_reg ? (DATA_W'(0) - y_reg) : y_reg;
                end
                st_next = A_DONE;
            end
            A_POW: begin
                // Square and multiply, lowest exponent bit first.
                if (exp_reg == '0) begin
                    res_next = acc_reg;
                    st_next  = A_DONE;
                end else if (exp_reg[0]) begin
                    x_next   = acc_reg;
                    y_next   = base_reg;
                    z_next   = '0;
                    ret_next = RET_ACC;
                    st_next  = A_MUL;
                end else if ((exp_reg >> 1) == '0) begin
                    exp_next = '0;
                end else begin
                    x_next   = base_reg;
                    y_next   = base_reg;
                    z_next   = '0;
                    ret_next = RET_BASE;
                    st_next  = A_MUL;
                end
            end
            A_DONE: begin
                st_next = A_IDLE;
            end
            default: begin
                st_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= A_IDLE;
        end else begin
            st_reg <= st_next;
        end
        ret_reg  <= ret_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
        step_reg <= step_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        mod_reg  <= mod_next;
    end

endmodule

`default_nettype wire

/* rtl/postfix_stack_evaluator_core.sv */
// Top level of the postfix stack evaluator: stream ports, operand stack and item sequencer.
`default_nettype none

// Evaluates postfix integer expressions one input word at a time and returns exactly one
// result word per input word. An input word pushes a number, applies a binary operator to
// the two top stack entries (left operand below, right operand on top), or ends the
// expression; the end word reports the final value and status and empties the stack.
// Arithmetic wraps in 64-bit two's complement; divide truncates toward zero and the
// remainder takes the sign of the dividend. Errors stick until the end word. The block
// handles one word at a time and deasserts s_tready from acceptance until the result is
// placed in the output register; a waiting result does not block the next input word.
// Push, end and ignored words do not use the arithmetic unit. The time of multiply, divide,
// remainder and power is set by the single iterative arithmetic unit: multiply runs one
// step per significant bit of the right operand (up to 64), divide and remainder run a
// fixed 64 steps, and power one multiply for each set exponent bit plus one squaring per
// exponent bit position below the highest set bit.
// The operand stack lives in a memory of STACK_DEPTH entries; the top entry is kept in a
// register so an operator needs only one memory read. No clearing pass is needed.
module postfix_stack_evaluator_core
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // number[63:0]
    input  wire logic [4:0]  s_tuser,   // action[1:0], operator[4:2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // value[63:0]
    output logic [2:0]       m_tuser,   // status[2:0]
    output logic             m_tlast    // final_res
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_FETCH    = 3'd2;
    localparam logic [2:0] ST_WAIT     = 3'd3;
    localparam logic [2:0] ST_RESP     = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [2:0]        err_reg, err_next;
    logic [1:0]        act_reg, act_next;
    logic [2:0]        op_reg, op_next;
    logic [DATA_W-1:0] num_reg, num_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic              fin_reg, fin_next;
    logic [2:0]        end_st_reg, end_st_next;
    logic [DATA_W-1:0] end_val_reg, end_val_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic [2:0]        m_user_reg, m_user_next;
    logic              m_last_reg, m_last_next;

    // Operand stack below the top entry; the top itself is top_reg.
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    logic              s_accept;
    logic              out_free;
    logic [DATA_W-1:0] top_val;
    alu_cmd_t          alu_cmd;
    logic              alu_done;
    logic [DATA_W-1:0] alu_result;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign top_val  = (cnt_reg == '0) ? '0 : top_reg;

    assign cnt_m1  = cnt_reg - CW'(1);
    assign cnt_m2  = cnt_reg - CW'(2);
    assign wr_addr = cnt_m1[AW-1:0];
    assign rd_addr = cnt_m2[AW-1:0];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        act_next     = act_reg;
        op_next      = op_reg;
        num_next     = num_reg;
        top_next     = top_reg;
        fin_next     = fin_reg;
        end_st_next  = end_st_reg;
        end_val_next = end_val_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        wr_en        = 1'b0;
        alu_cmd      = '{start: 1'b0, op: op_reg};

        // The result register empties when the sink takes the word.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    act_next   = s_tuser[1:0];
                    op_next    = s_tuser[4:2];
                    num_next   = s_tdata;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                fin_next   = 1'b0;
                state_next = ST_RESP;
                if (act_reg == ACT_END) begin
                    fin_next = 1'b1;
                    if (err_reg != STAT_OK) begin
                        end_st_next  = err_reg;
                        end_val_next = '0;
                    end else if (cnt_reg == '0) begin
                        end_st_next  = STAT_EMPTY;
                        end_val_next = '0;
                    end else begin
                        end_st_next  = (cnt_reg > CW'(1)) ? STAT_EXTRA : STAT_OK;
                        end_val_next = top_reg;
                    end
                    cnt_next = '0;
                    err_next = STAT_OK;
                end else if (err_reg != STAT_OK) begin
                    // Sticky error: the word only reports.
                    state_next = ST_RESP;
                end else if (act_reg == ACT_PUSH) begin
                    if (cnt_reg == CW'(STACK_DEPTH)) begin
                        err_next = STAT_OVERFLOW;
                    end else begin
                        wr_en    = (cnt_reg != '0);
                        top_next = num_reg;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end else if (act_reg == ACT_OPER && op_reg <= OP_POW) begin
                    if (cnt_reg < CW'(2)) begin
                        err_next = STAT_UNDERFLOW;
                    end else begin
                        // The left operand is read from the stack memory this cycle.
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                if ((op_reg == OP_DIV) && (top_reg == '0)) begin
                    err_next   = STAT_DIVZERO;
                    state_next = ST_RESP;
                end else if ((op_reg == OP_MOD) && (top_reg == '0)) begin
                    err_next   = STAT_MODZERO;
                    state_next = ST_RESP;
                end else if ((op_reg == OP_POW) && top_reg[DATA_W-1]) begin
                    err_next   = STAT_NEGEXP;
                    state_next = ST_RESP;
                end else begin
                    alu_cmd.start = 1'b1;
                    state_next    = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (alu_done) begin
                    top_next   = alu_result;
                    cnt_next   = cnt_m1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = fin_reg ? end_val_reg : top_val;
                    m_user_next  = fin_reg ? end_st_reg : err_reg;
                    m_last_next  = fin_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            err_reg     <= STAT_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg     <= act_next;
        op_reg      <= op_next;
        num_reg     <= num_next;
        top_reg     <= top_next;
        fin_reg     <= fin_next;
        end_st_reg  <= end_st_next;
        end_val_reg <= end_val_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
        m_last_reg  <= m_last_next;
    end

    // Stack memory: one write port for the entry pushed below the top, one registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= top_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    pse_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (alu_cmd),
        .opnd_a  (top_reg),
        .opnd_b  (rd_data_reg),
        .done    (alu_done),
        .result  (alu_result)
    );

    // The stack never holds more entries than it has room for.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count exceeds depth");

    // The arithmetic unit only finishes while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> state_reg == ST_WAIT)
        else $error("arithmetic unit finished outside the wait state");

    // No operation is started while an error is pending or with fewer than two operands.
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_cmd.start |-> (err_reg == STAT_OK) && (cnt_reg >= CW'(2)))
        else $error("operation started with an error pending or too few operands");

    // A successful push grows the stack by exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DISPATCH && act_reg == ACT_PUSH && err_reg == STAT_OK &&
         cnt_reg != CW'(STACK_DEPTH)) |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("push did not grow the stack by one");

    // An end word leaves an empty stack and no error behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DISPATCH && act_reg == ACT_END) |=>
        (cnt_reg == '0) && (err_reg == STAT_OK))
        else $error("end word did not clear the stack");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the postfix stack evaluator core.
module testbench
    import pse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int TARGET_WORDS = 950;
    localparam int MAX_PRINTED = 40;

    // Codes that the block must ignore.
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic [2:0] OP_BAD6 = 3'd6;
    localparam logic [2:0] OP_BAD7 = 3'd7;

    localparam logic [63:0] MIN_INT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_INT = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MINUS_ONE = 64'hffff_ffff_ffff_ffff;

    typedef struct {
        logic [1:0]  action;
        logic [63:0] number;
        logic [2:0]  opcode;
        bit          hold;      // wait until every result is back before sending
    } token_t;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] value;
        logic        fin;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [4:0]  s_tuser = '0;      // action[1:0], operator[4:2]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // value[63:0]
    logic [2:0]  m_tuser;           // status[2:0]
    logic        m_tlast;

    token_t  pending_words[$];
    answer_t expected_answers[$];
    token_t  word_on_bus;
    bit      hold_next = 1'b0;
    int      counted_words = 0;
    int      words_accepted = 0;
    int      results_checked = 0;
    int      ends_checked = 0;
    int      errors = 0;
    logic [7:0] statuses_seen = '0;

    // Predictor state: operand stack, fill level and sticky error.
    logic [63:0] ev_stack[DEPTH];
    int          ev_count = 0;
    logic [2:0]  ev_err = STAT_OK;

    postfix_stack_evaluator_core #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] magnitude_of(logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    // Exact power by repeated squaring, wrapping at 64 bits.
    function automatic logic [63:0] wrapped_power(logic [63:0] base, logic [63:0] ex);
        logic [63:0] acc;
        acc = 64'd1;
        while (ex != 64'd0) begin
            if (ex[0])
                acc = acc * base;
            base = base * base;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // Advances the predicted stack by one word and returns the result it should produce.
    function automatic answer_t evaluate_word(token_t w);
        answer_t     r;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] q;
        logic [63:0] v;
        bit          apply;
        r.fin = 1'b0;
        if (w.action == ACT_END) begin
            r.fin = 1'b1;
            r.value = 64'd0;
            if (ev_err != STAT_OK) begin
                r.status = ev_err;
            end else if (ev_count == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                r.value = ev_stack[ev_count - 1];
                r.status = (ev_count > 1) ? STAT_EXTRA : STAT_OK;
            end
            ev_count = 0;
            ev_err = STAT_OK;
            return r;
        end
        if (ev_err == STAT_OK) begin
            if (w.action == ACT_PUSH) begin
                if (ev_count >= DEPTH) begin
                    ev_err = STAT_OVERFLOW;
                end else begin
                    ev_stack[ev_count] = w.number;
                    ev_count++;
                end
            end else if (w.action == ACT_OPER && w.opcode <= OP_POW) begin
                if (ev_count < 2) begin
                    ev_err = STAT_UNDERFLOW;
                end else begin
                    a = ev_stack[ev_count - 1];
                    b = ev_stack[ev_count - 2];
                    apply = 1'b1;
                    v = 64'd0;
                    case (w.opcode)
                        OP_ADD: v = b + a;
                        OP_SUB: v = b - a;
                        OP_MUL: v = b * a;
                        OP_DIV: begin
                            if (a == 64'd0) begin
                                ev_err = STAT_DIVZERO;
                                apply = 1'b0;
                            end else begin
                                q = magnitude_of(b) / magnitude_of(a);
                                v = (a[63] != b[63]) ? 64'd0 - q : q;
                            end
                        end
                        OP_MOD: begin
                            if (a == 64'd0) begin
                                ev_err = STAT_MODZERO;
                                apply = 1'b0;
                            end else begin
                                q = magnitude_of(b) % magnitude_of(a);
                                v = b[63] ? 64'd0 - q : q;
                            end
                        end
                        default: begin
                            if (a[63]) begin
                                ev_err = STAT_NEGEXP;
                                apply = 1'b0;
                            end else begin
                                v = wrapped_power(b, a);
                            end
                        end
                    endcase
                    if (apply) begin
                        ev_count--;
                        ev_stack[ev_count - 1] = v;
                    end
                end
            end
        end
        r.status = ev_err;
        r.value = (ev_count == 0) ? 64'd0 : ev_stack[ev_count - 1];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic queue_word(input logic [1:0] action, input logic [63:0] number,
                              input logic [2:0] opcode);
        token_t t;
        t.action = action;
        t.number = number;
        t.opcode = opcode;
        t.hold = hold_next;
        hold_next = 1'b0;
        pending_words.push_back(t);
        // Words the block ignores do not count toward the stimulus size.
        if (!(action == ACT_NONE || (action == ACT_OPER && opcode > OP_POW)))
            counted_words++;
    endtask

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return MIN_INT;
                    1: return MAX_INT;
                    2: return MINUS_ONE;
                    3: return 64'd1;
                    default: return 64'd0;
                endcase
            end
            1, 2: return {$urandom, $urandom};
            default: return 64'($signed($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    // Driver: presents queued words and keeps the predictor in step with what is accepted.
    always @(posedge aclk) begin
        bit gap;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_answers.push_back(evaluate_word(word_on_bus));
                words_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                gap = (words_accepted >= 300 && words_accepted < 500) ? 1'b0
                      : ($urandom_range(0, 99) < 10);
                if (pending_words.size() != 0 && !gap
                        && !(pending_words[0].hold && expected_answers.size() != 0)) begin
                    word_on_bus = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= word_on_bus.number;
                    s_tuser <= {word_on_bus.opcode, word_on_bus.action};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result word with the oldest prediction.
    always @(posedge aclk) begin
        answer_t exp_ans;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf(
                        "result word with nothing expected: status %0d value %h",
                        m_tuser, m_tdata));
                end else begin
                    exp_ans = expected_answers.pop_front();
                    if (m_tuser !== exp_ans.status || m_tdata !== exp_ans.value
                            || m_tlast !== exp_ans.fin)
                        report_mismatch($sformatf(
                            "result %0d: got status %0d value %h last %b, want %0d %h %b",
                            results_checked, m_tuser, m_tdata, m_tlast,
                            exp_ans.status, exp_ans.value, exp_ans.fin));
                end
                results_checked++;
                if (m_tlast === 1'b1)
                    ends_checked++;
                if (!$isunknown(m_tuser))
                    statuses_seen[m_tuser] = 1'b1;
            end
            if (results_checked >= 300 && results_checked < 500)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 10);
        end
    end

    // Watchdog: cycles without any accepted word on either side.
    always @(posedge aclk) begin
        int quiet_cycles;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL postfix_stack_evaluator_core");
                $finish;
            end
        end
    end

    initial begin
        int kind;
        int total_operands;
        int pushed;
        int depth;
        int n;
        logic [2:0] op;

        // Directed: empty end, most negative over minus one for both divide and
        // remainder, ignored codes, leftover values on end.
        queue_word(ACT_END, 64'd0, OP_ADD);
        queue_word(ACT_PUSH, MIN_INT, OP_ADD);
        queue_word(ACT_PUSH, MINUS_ONE, OP_ADD);
        queue_word(ACT_OPER, 64'd0, OP_MOD);
        queue_word(ACT_PUSH, MAX_INT, OP_ADD);
        queue_word(ACT_OPER, 64'd0, OP_ADD);
        queue_word(ACT_PUSH, MIN_INT, OP_ADD);
        queue_word(ACT_PUSH, MINUS_ONE, OP_ADD);
        queue_word(ACT_OPER, 64'd0, OP_DIV);
        queue_word(ACT_OPER, 64'd0, OP_BAD6);
        queue_word(ACT_NONE, MAX_INT, OP_BAD7);
        queue_word(ACT_END, 64'd0, OP_ADD);
        // Zero to the power zero, multiply, then a negative exponent that sticks.
        queue_word(ACT_PUSH, 64'd0, OP_ADD);
        queue_word(ACT_PUSH, 64'd0, OP_ADD);
        queue_word(ACT_OPER, 64'd0, OP_POW);
        queue_word(ACT_PUSH, 64'($signed(-3)), OP_ADD);
        queue_word(ACT_OPER, 64'd0, OP_MUL);
        queue_word(ACT_PUSH, MINUS_ONE, OP_ADD);
        queue_word(ACT_OPER, 64'd0, OP_POW);
        queue_word(ACT_OPER, 64'd0, OP_ADD);
        queue_word(ACT_END, 64'd0, OP_ADD);
        // Underflow, divide by zero and remainder by zero; the sender drains first.
        hold_next = 1'b1;
        queue_word(ACT_OPER, 64'd0, OP_SUB);
        queue_word(ACT_END, 64'd0, OP_ADD);
        queue_word(ACT_PUSH, 64'd7, OP_ADD);
        queue_word(ACT_PUSH, 64'd0, OP_ADD);
        queue_word(ACT_OPER, 64'd0, OP_DIV);
        queue_word(ACT_END, 64'd0, OP_ADD);
        queue_word(ACT_PUSH, 64'd7, OP_ADD);
        queue_word(ACT_PUSH, 64'd0, OP_ADD);
        queue_word(ACT_OPER, 64'd0, OP_MOD);
        queue_word(ACT_END, 64'd0, OP_ADD);

        // Random expressions; now and then the sender waits for all results first.
        while (counted_words < TARGET_WORDS) begin
            if ($urandom_range(0, 19) == 0)
                hold_next = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // Well-formed expression with random operands and operators.
                total_operands = $urandom_range(1, 10);
                pushed = 0;
                depth = 0;
                while (pushed < total_operands || depth > 1) begin
                    if (depth >= 2
                            && (pushed == total_operands || $urandom_range(0, 2) == 0)) begin
                        op = 3'($urandom_range(0, 5));
                        if (op == OP_POW && $urandom_range(0, 4) != 0) begin
                            // Mostly small exponents keep power fast.
                            queue_word(ACT_PUSH, 64'($urandom_range(0, 70)), 3'($urandom));
                            depth++;
                        end
                        queue_word(ACT_OPER, {$urandom, $urandom}, op);
                        depth--;
                    end else begin
                        queue_word(ACT_PUSH, pick_operand(), 3'($urandom));
                        pushed++;
                        depth++;
                    end
                end
                if ($urandom_range(0, 9) == 0)
                    queue_word(ACT_PUSH, pick_operand(), 3'($urandom));
                queue_word(ACT_END, {$urandom, $urandom}, 3'($urandom));
            end else if (kind == 7) begin
                // Deep fill that may reach the stack limit and sometimes overflows it.
                n = $urandom_range(58, 68);
                repeat (n)
                    queue_word(ACT_PUSH, pick_operand(), 3'($urandom));
                repeat ($urandom_range(0, 3))
                    queue_word(ACT_OPER, {$urandom, $urandom}, 3'($urandom_range(0, 5)));
                queue_word(ACT_END, {$urandom, $urandom}, 3'($urandom));
            end else begin
                // Noise: any action and operator code, usually closed by an end.
                repeat ($urandom_range(1, 8))
                    queue_word(2'($urandom_range(0, 3)), pick_operand(),
                               3'($urandom_range(0, 7)));
                if ($urandom_range(0, 4) != 0)
                    queue_word(ACT_END, {$urandom, $urandom}, 3'($urandom));
            end
        end
        queue_word(ACT_END, 64'd0, OP_ADD);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(posedge aclk);
        // A stray result word would show up within the longest short-item latency.
        repeat (200) @(posedge aclk);

        $display("Sent %0d words; checked %0d results including %0d expression ends.",
                 words_accepted, results_checked, ends_checked);
        $display("Status codes observed (bit per code): %b, %0d mismatches.",
                 statuses_seen, errors);
        if (errors == 0)
            $display("PASS postfix_stack_evaluator_core");
        else
            $display("FAIL postfix_stack_evaluator_core");
        $finish;
    end

endmodule
